// ===== rtl/clsr_pkg.sv =====
// Package with constants, types and modular helpers for the combined LCG shuffle generator.
package clsr_pkg;

  localparam int unsigned TABLE_DEPTH = 32;
  localparam int unsigned IDX_W       = $clog2(TABLE_DEPTH);
  localparam int unsigned WARM_STEPS  = TABLE_DEPTH + 8;
  localparam int unsigned CNT_W       = $clog2(WARM_STEPS);

  localparam logic [30:0] MOD_A        = 31'd2147483563;
  localparam logic [30:0] MOD_B        = 31'd2147483399;
  localparam logic [30:0] MOD_A_LESS1  = 31'd2147483562;
  localparam logic [31:0] MOD_A_TWICE  = 32'd4294967126;
  localparam logic [15:0] MUL_A        = 16'd40014;
  localparam logic [15:0] MUL_B        = 16'd40692;
  // 2^31 is congruent to these values modulo the two moduli.
  localparam logic [7:0]  FOLD_A       = 8'd85;
  localparam logic [7:0]  FOLD_B       = 8'd249;
  localparam logic [31:0] SECOND_RESET = 32'd123456789;
  localparam logic [23:0] FRAC_MAX     = 24'd16777213;

  // The table index is last_combined divided by the bucket size, done as a
  // multiplication by a rounded-up reciprocal that is exact for 31-bit values.
  localparam logic [63:0] BUCKET_SIZE  = 64'd1 + 64'd2147483562 / 64'(TABLE_DEPTH);
  localparam int unsigned BUCKET_W     = $clog2(BUCKET_SIZE);
  localparam int unsigned IDX_SHIFT    = 31 + BUCKET_W;
  localparam logic [63:0] IDX_RECIP_FULL =
    ((64'd1 << IDX_SHIFT) + BUCKET_SIZE - 64'd1) / BUCKET_SIZE;
  localparam logic [31:0] IDX_RECIP    = IDX_RECIP_FULL[31:0];
  localparam int unsigned IDX_PROD_W   = 63;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_WARM_MUL,
    ST_WARM_FOLD,
    ST_IDX,
    ST_MUL,
    ST_FOLD,
    ST_COMB,
    ST_FRAC,
    ST_OUT
  } state_t;

  function automatic logic [47:0] mul_a(input logic [31:0] x);
    return 48'(x) * 48'(MUL_A);
  endfunction

  function automatic logic [47:0] mul_b(input logic [31:0] x);
    return 48'(x) * 48'(MUL_B);
  endfunction

  function automatic logic [30:0] fold_a(input logic [47:0] p);
    logic [31:0] s;
    s = 32'(p[47:31]) * 32'(FOLD_A) + 32'(p[30:0]);
    if (s >= {1'b0, MOD_A}) begin
      s = s - {1'b0, MOD_A};
    end
    return s[30:0];
  endfunction

  function automatic logic [30:0] fold_b(input logic [47:0] p);
    logic [31:0] s;
    s = 32'(p[47:31]) * 32'(FOLD_B) + 32'(p[30:0]);
    if (s >= {1'b0, MOD_B}) begin
      s = s - {1'b0, MOD_B};
    end
    return s[30:0];
  endfunction

endpackage

// ===== rtl/combined_lcg_shuffle_random_unit.sv =====
// Combined two-generator LCG random unit with a shuffle table held in a synchronous RAM.
//
// Input channel (in_*): each transaction carries the caller's signed 32-bit seed.
// A seed of zero or less reseeds the unit before the draw.
// Result channel (out_*): one transaction per input, carrying the advanced seed,
// the raw combined deviate and its Q0.24 fraction.
// An ordinary draw runs the chain multiply at acceptance, then the modular fold, the table
// read-modify-write, the fraction remainder and the fraction correction into the result
// register; the unit takes no new input until that result is loaded.
// A reseed first runs the 40 warm-up steps of the first generator (multiply, then fold),
// then forms the table index and multiplies before the ordinary steps.
// The next input is taken while a finished result still waits in the output
// register; a stalled receiver holds the unit only when a second result is ready.
// Reset loads the second generator with 123456789, clears the last combined
// value and marks every table entry as reading zero; no clearing pass is needed.
module combined_lcg_shuffle_random_unit
  import clsr_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [31:0] in_tdata,   // [31:0] seed_in
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [87:0] out_tdata   // [30:0] seed_out, [61:31] raw_value, [85:62] fraction_q24
);

  state_t state_r, state_nxt;

  logic [31:0]            x_r;
  logic [31:0]            y_r;
  logic [47:0]            prod_a_r;
  logic [47:0]            prod_b_r;
  logic [CNT_W-1:0]       cnt_r;
  logic [30:0]            lc_r;
  logic [IDX_PROD_W-1:0]  idx_prod_r;
  logic [31:0]            frac_rem_r;
  logic [TABLE_DEPTH-1:0] valid_r;
  logic [30:0]            rd_data_r;
  logic                   rd_vld_r;
  logic                   out_vld_r;
  logic [30:0]            out_seed_r;
  logic [30:0]            out_raw_r;
  logic [23:0]            out_frac_r;

  logic [30:0]            table_mem [TABLE_DEPTH];

  logic                   in_acc;
  logic                   reseed;
  logic [31:0]            seed_mag;
  logic [30:0]            x_fold;
  logic [30:0]            y_fold;
  logic [IDX_PROD_W-1:0]  idx_full;
  logic [IDX_W-1:0]       idx;
  logic [30:0]            entry;
  logic signed [32:0]     diff;
  logic signed [32:0]     diff_wrap;
  logic [30:0]            comb_val;
  logic [31:0]            frac_rem;
  logic [24:0]            frac_q;
  logic [23:0]            frac_val;
  logic                   mem_rd_en;
  logic                   mem_wr_en;
  logic [IDX_W-1:0]       mem_wr_addr;
  logic [30:0]            mem_wr_data;
  logic                   out_load;

  assign in_acc   = in_tvalid && in_tready;
  assign reseed   = (in_tdata == 32'd0) || in_tdata[31];
  assign seed_mag = (in_tdata == 32'd0) ? 32'd1 : (32'd0 - in_tdata);

  assign x_fold = fold_a(prod_a_r);
  assign y_fold = fold_b(prod_b_r);

  assign idx_full = idx_prod_r >> IDX_SHIFT;
  assign idx = (idx_full > IDX_PROD_W'(TABLE_DEPTH - 1)) ? IDX_W'(TABLE_DEPTH - 1)
                                                        : idx_full[IDX_W-1:0];

  assign entry     = rd_vld_r ? rd_data_r : 31'd0;
  assign diff      = $signed({2'b00, entry}) - $signed({1'b0, y_r});
  assign diff_wrap = diff + $signed({2'b00, MOD_A_LESS1});
  assign comb_val  = (diff < 33'sd1) ? diff_wrap[30:0] : diff[30:0];

  // Remainder of lc*2^24 against the modulus after taking lc>>7 as the quotient.
  assign frac_rem = {1'b0, lc_r[6:0], 24'd0} + 32'(lc_r[30:7]) * 32'(FOLD_A);
  assign frac_q   = {1'b0, lc_r[30:7]}
                  + 25'(frac_rem_r >= {1'b0, MOD_A})
                  + 25'(frac_rem_r >= MOD_A_TWICE);
  assign frac_val = (frac_q > {1'b0, FRAC_MAX}) ? FRAC_MAX : frac_q[23:0];

  // Reads and writes of the table fall in different states, so an entry is
  // never read in the cycle it is written.
  always_comb begin
    state_nxt   = state_r;
    in_tready   = 1'b0;
    mem_rd_en   = 1'b0;
    mem_wr_en   = 1'b0;
    mem_wr_addr = idx;
    mem_wr_data = x_r[30:0];
    out_load    = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
        in_tready = 1'b1;
        if (in_tvalid) begin
          if (reseed) begin
            state_nxt = ST_WARM_MUL;
          end else begin
            mem_rd_en = 1'b1;
            state_nxt = ST_FOLD;
          end
        end
      end
      ST_WARM_MUL: begin
        state_nxt = ST_WARM_FOLD;
      end
      ST_WARM_FOLD: begin
        mem_wr_addr = cnt_r[IDX_W-1:0];
        mem_wr_data = x_fold;
        mem_wr_en   = (cnt_r < CNT_W'(TABLE_DEPTH));
        state_nxt   = (cnt_r == '0) ? ST_IDX : ST_WARM_MUL;
      end
      ST_IDX: begin
        state_nxt = ST_MUL;
      end
      ST_MUL: begin
        mem_rd_en = 1'b1;
        state_nxt = ST_FOLD;
      end
      ST_FOLD: begin
        state_nxt = ST_COMB;
      end
      ST_COMB: begin
        mem_wr_en = 1'b1;
        state_nxt = ST_FRAC;
      end
      ST_FRAC: begin
        state_nxt = ST_OUT;
      end
      ST_OUT: begin
        if (!out_vld_r || out_tready) begin
          out_load  = 1'b1;
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      y_r        <= SECOND_RESET;
      lc_r       <= '0;
      idx_prod_r <= '0;
      valid_r    <= '0;
      out_vld_r  <= 1'b0;
    end else begin
      if (mem_wr_en) begin
        valid_r[mem_wr_addr] <= 1'b1;
      end
      if (out_load) begin
        out_vld_r <= 1'b1;
      end else if (out_tready) begin
        out_vld_r <= 1'b0;
      end
      unique case (state_r)
        ST_IDLE: begin
          if (in_acc && reseed) begin
            y_r <= seed_mag;
          end
        end
        ST_WARM_FOLD: begin
          if (cnt_r == '0) begin
            lc_r <= x_fold;
          end
        end
        ST_IDX: begin
          idx_prod_r <= IDX_PROD_W'(lc_r) * IDX_PROD_W'(IDX_RECIP);
        end
        ST_FOLD: begin
          y_r <= {1'b0, y_fold};
        end
        ST_COMB: begin
          lc_r <= comb_val;
        end
        ST_FRAC: begin
          idx_prod_r <= IDX_PROD_W'(lc_r) * IDX_PROD_W'(IDX_RECIP);
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    unique case (state_r)
      ST_IDLE: begin
        if (in_acc) begin
          if (reseed) begin
            x_r   <= seed_mag;
            cnt_r <= CNT_W'(WARM_STEPS - 1);
          end else begin
            prod_a_r <= mul_a({1'b0, in_tdata[30:0]});
            prod_b_r <= mul_b(y_r);
          end
        end
      end
      ST_WARM_MUL: begin
        prod_a_r <= mul_a(x_r);
      end
      ST_WARM_FOLD: begin
        x_r   <= {1'b0, x_fold};
        cnt_r <= cnt_r - CNT_W'(1);
      end
      ST_MUL: begin
        prod_a_r <= mul_a(x_r);
        prod_b_r <= mul_b(y_r);
      end
      ST_FOLD: begin
        x_r <= {1'b0, x_fold};
      end
      ST_FRAC: begin
        frac_rem_r <= frac_rem;
      end
      default: begin
      end
    endcase
    if (mem_rd_en) begin
      rd_vld_r <= valid_r[idx];
    end
    if (out_load) begin
      out_seed_r <= x_r[30:0];
      out_raw_r  <= lc_r;
      out_frac_r <= frac_val;
    end
  end

  always_ff @(posedge clk) begin
    if (mem_rd_en) begin
      rd_data_r <= table_mem[idx];
    end
    if (mem_wr_en) begin
      table_mem[mem_wr_addr] <= mem_wr_data;
    end
  end

  assign out_tvalid = out_vld_r;
  assign out_tdata  = {2'b00, out_frac_r, out_raw_r, out_seed_r};

`ifndef SYNTHESIS
  a_raw_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (out_tdata[61:31] != 31'd0) && (out_tdata[61:31] < MOD_A))
    else $error("raw value out of range");

  a_frac_max: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (out_tdata[85:62] <= FRAC_MAX))
    else $error("fraction above clamp");

  a_seed_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (out_tdata[30:0] < MOD_A))
    else $error("seed not reduced");

  a_draw_start: assert property (@(posedge clk) disable iff (!rst_n)
    (in_tvalid && in_tready && !reseed) |=> (state_r == ST_FOLD))
    else $error("ordinary draw did not start");
`endif

endmodule

// ===== dv/combined_lcg_shuffle_random_unit_tb.sv =====
// Self-checking testbench for the combined LCG random unit with its shuffle table.
module combined_lcg_shuffle_random_unit_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int          SHUFFLE_DEPTH = clsr_pkg::TABLE_DEPTH;
  localparam longint unsigned MODULUS_X = 64'd2147483563;
  localparam longint unsigned MODULUS_Y = 64'd2147483399;
  localparam longint unsigned MULT_X    = 64'd40014;
  localparam longint unsigned MULT_Y    = 64'd40692;
  localparam longint unsigned WRAP_ADD  = 64'd2147483562;
  localparam longint unsigned BUCKET    = 64'd1 + 64'd2147483562 / SHUFFLE_DEPTH;
  localparam longint unsigned FRAC_CAP  = 64'd16777213;
  localparam longint unsigned GEN_Y_RST = 64'd123456789;
  localparam int              MAX_IDLE  = 18;
  localparam int              DRAIN_CYCLES = 120;

  typedef struct packed {
    logic [30:0] seed_out;
    logic [30:0] raw_value;
    logic [23:0] fraction_q24;
  } draw_t;

  logic        clk;
  logic        rst_n;
  logic        in_tvalid;
  logic        in_tready;
  logic [31:0] in_tdata;
  logic        out_tvalid;
  logic        out_tready;
  logic [87:0] out_tdata;

  longint unsigned gen_y;
  longint unsigned prev_comb;
  longint unsigned shuffle [SHUFFLE_DEPTH];
  logic [30:0]     chain_seed;

  draw_t pending_draws[$];
  int    error_count;
  bit    in_idle_on;
  bit    out_idle_on;

  combined_lcg_shuffle_random_unit DUT (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  initial begin
    #2ms;
    $display("[FAIL] regression broken");
    $finish;
  end

  function automatic longint unsigned lcg_next(longint unsigned x, longint unsigned mul,
                                               longint unsigned modulus);
    return (x * mul) % modulus;
  endfunction

  task automatic reset_generator();
    gen_y     = GEN_Y_RST;
    prev_comb = 0;
    for (int i = 0; i < SHUFFLE_DEPTH; i++) begin
      shuffle[i] = 0;
    end
    chain_seed = 31'd1;
  endtask

  // Advances the generator pair for one accepted seed and queues the draw it yields.
  task automatic predict_draw(input logic [31:0] seed_word);
    longint unsigned x;
    longint unsigned idx;
    longint unsigned frac;
    longint          comb;
    draw_t           d;
    if (seed_word == 32'd0 || seed_word[31]) begin
      x = (64'h1_0000_0000 - longint'(seed_word)) & 64'hFFFF_FFFF;
      if (x == 0) begin
        x = 1;
      end
      gen_y = x;
      for (int step = SHUFFLE_DEPTH + 7; step >= 0; step--) begin
        x = lcg_next(x, MULT_X, MODULUS_X);
        if (step < SHUFFLE_DEPTH) begin
          shuffle[step] = x;
        end
      end
      prev_comb = shuffle[0];
    end else begin
      x = longint'(seed_word);
    end
    x     = lcg_next(x, MULT_X, MODULUS_X);
    gen_y = lcg_next(gen_y, MULT_Y, MODULUS_Y);
    idx   = prev_comb / BUCKET;
    if (idx >= SHUFFLE_DEPTH) begin
      idx = 64'(SHUFFLE_DEPTH - 1);
    end
    comb = longint'(shuffle[idx]) - longint'(gen_y);
    shuffle[idx] = x;
    if (comb < 1) begin
      comb = comb + longint'(WRAP_ADD);
    end
    prev_comb = longint'(comb) & 64'h7FFF_FFFF;
    frac = (prev_comb << 24) / MODULUS_X;
    if (frac > FRAC_CAP) begin
      frac = FRAC_CAP;
    end
    d.seed_out     = x[30:0];
    d.raw_value    = prev_comb[30:0];
    d.fraction_q24 = frac[23:0];
    chain_seed     = d.seed_out;
    pending_draws.push_back(d);
  endtask

  task automatic report_mismatch(input string msg);
    if (error_count < 40) begin
      $display("mismatch at %0t: %s", $realtime, msg);
    end
    error_count++;
  endtask

  task automatic send_seed(input logic [31:0] seed_word);
    int gap;
    gap = in_idle_on ? $urandom_range(0, MAX_IDLE) : 0;
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= seed_word;
    do @(posedge clk); while (!in_tready);
    predict_draw(seed_word);
  endtask

  initial begin : result_sink
    int    stall;
    draw_t got;
    draw_t want;
    out_tready = 1'b0;
    do @(posedge clk); while (!rst_n);
    forever begin
      stall = out_idle_on ? $urandom_range(0, MAX_IDLE) : 0;
      if (stall > 0) begin
        out_tready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_tready <= 1'b1;
      do @(posedge clk); while (!out_tvalid);
      got.seed_out     = out_tdata[30:0];
      got.raw_value    = out_tdata[61:31];
      got.fraction_q24 = out_tdata[85:62];
      if (pending_draws.size() == 0) begin
        report_mismatch($sformatf("unexpected result seed_out=%0d raw_value=%0d",
                                  got.seed_out, got.raw_value));
      end else begin
        want = pending_draws.pop_front();
        if (got.seed_out !== want.seed_out) begin
          report_mismatch($sformatf("seed_out got %0d want %0d", got.seed_out, want.seed_out));
        end
        if (got.raw_value !== want.raw_value) begin
          report_mismatch($sformatf("raw_value got %0d want %0d",
                                    got.raw_value, want.raw_value));
        end
        if (got.fraction_q24 !== want.fraction_q24) begin
          report_mismatch($sformatf("fraction_q24 got %0d want %0d",
                                    got.fraction_q24, want.fraction_q24));
        end
      end
    end
  end

  task automatic test_draw_from_reset();
    in_idle_on  = 1'b0;
    out_idle_on = 1'b0;
    send_seed(32'd1);
    send_seed(32'd2147483647);
    send_seed(32'd12345);
  endtask

  task automatic test_reseed_extremes();
    in_idle_on  = 1'b1;
    out_idle_on = 1'b0;
    send_seed(32'd0);
    send_seed(32'hFFFF_FFFF);
    send_seed(-32'sd2147483647);
    send_seed(32'h8000_0000);
    send_seed(-32'sd123456789);
  endtask

  task automatic test_seed_residues();
    in_idle_on  = 1'b0;
    out_idle_on = 1'b1;
    send_seed(32'd2147483563);
    send_seed(32'd2147483562);
    send_seed(32'd2147483399);
    send_seed(-32'sd2147483563);
    send_seed({1'b0, chain_seed});
    send_seed(32'd2147483564);
  endtask

  task automatic test_chained_draws();
    in_idle_on  = 1'b1;
    out_idle_on = 1'b1;
    send_seed(-32'sd1);
    repeat (8) send_seed({1'b0, chain_seed});
  endtask

  task automatic test_random_mix(input int count);
    int          pick;
    logic [31:0] seed_word;
    for (int i = 0; i < count; i++) begin
      if (i % 30 == 0) begin
        in_idle_on  = 1'($urandom_range(0, 1));
        out_idle_on = 1'($urandom_range(0, 1));
      end
      pick = $urandom_range(0, 99);
      if (pick < 78 && chain_seed != 31'd0) begin
        seed_word = {1'b0, chain_seed};
      end else if (pick < 88) begin
        seed_word = $urandom();
        seed_word[31] = 1'b1;
      end else if (pick < 97) begin
        seed_word = $urandom();
      end else begin
        seed_word = 32'd0;
      end
      send_seed(seed_word);
    end
  endtask

  initial begin : main_sequence
    error_count = 0;
    in_idle_on  = 1'b0;
    out_idle_on = 1'b0;
    rst_n       = 1'b0;
    in_tvalid   = 1'b0;
    in_tdata    = 32'd0;
    reset_generator();
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_draw_from_reset();
    test_reseed_extremes();
    test_seed_residues();
    test_chained_draws();
    test_random_mix(430);

    in_tvalid <= 1'b0;
    while (pending_draws.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (error_count == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
